// File: hdl/pitch_yaw_difference_angles_assert.svh
// Assertion helpers used by the checker file.
`ifndef PITCH_YAW_DIFFERENCE_ANGLES_ASSERT_SVH
`define PITCH_YAW_DIFFERENCE_ANGLES_ASSERT_SVH

// Clocked check, masked while reset is high.
`define PYD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pyd check failed");

// Clocked check that also holds through reset.
`define PYD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pyd check failed");

`endif

// File: hdl/pyd_pkg.sv
`timescale 1ns / 1ps
package pyd_pkg;

  localparam int CW         = 16;
  localparam int AFB        = 8;
  localparam int CS         = 16;
  localparam int ACC_FRAC   = 20;
  localparam int PRESCALE   = 24;
  localparam int SQ         = CW;
  localparam int RAD_W      = 2 * CW;
  localparam int REM_W      = CW + 4;
  localparam int OP_W       = CW + 1;
  localparam int XY_W       = CW + PRESCALE + 4;
  localparam int ANG_W      = 31;
  localparam int OUT_W      = AFB + 9;
  localparam int IDX_W      = $clog2(CS);
  localparam int RND_SH     = ACC_FRAC - AFB;
  localparam int SIDE       = 2 + SQ;
  localparam int DEPTH      = 7 + SQ + CS;

  localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(64'sd90 <<< ACC_FRAC);
  localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(64'sd180 <<< ACC_FRAC);
  localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(64'sd360 <<< ACC_FRAC);
  localparam logic [OUT_W-1:0]        FULL   = OUT_W'(64'd360 << AFB);

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [CW-1:0] tz;
  } vec_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [CW-1:0]    root;
  } sq_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] acc;
    logic                    held;
  } cd_t;

  // atan(2^-i) in degrees, ACC_FRAC fraction bits
  function automatic logic signed [ANG_W-1:0] stage_angle(input logic [IDX_W-1:0] i);
    int     k;
    longint v;
    k = int'(i);
    case (k)
      0:  v = 64'sd47185920;
      1:  v = 64'sd27855475;
      2:  v = 64'sd14718068;
      3:  v = 64'sd7471121;
      4:  v = 64'sd3750058;
      5:  v = 64'sd1876857;
      6:  v = 64'sd938658;
      7:  v = 64'sd469357;
      8:  v = 64'sd234682;
      9:  v = 64'sd117342;
      10: v = 64'sd58671;
      11: v = 64'sd29335;
      default: v = (64'sd60078979 + (64'sd1 <<< (k - 1))) >>> k;
    endcase
    return ANG_W'(v);
  endfunction

endpackage

// File: hdl/pyd_if.sv
`timescale 1ns / 1ps
interface pyd_vec_if;
  logic                          valid;
  logic                          ready;
  logic signed [pyd_pkg::CW-1:0] cur_x;
  logic signed [pyd_pkg::CW-1:0] cur_y;
  logic signed [pyd_pkg::CW-1:0] cur_z;
  logic signed [pyd_pkg::CW-1:0] to_x;
  logic signed [pyd_pkg::CW-1:0] to_y;
  logic signed [pyd_pkg::CW-1:0] to_z;
  modport source (output valid, cur_x, cur_y, cur_z, to_x, to_y, to_z, input ready);
  modport sink (input valid, cur_x, cur_y, cur_z, to_x, to_y, to_z, output ready);
endinterface

interface pyd_delta_if;
  logic                       valid;
  logic                       ready;
  logic [pyd_pkg::OUT_W-1:0]  pitch_delta;
  logic [pyd_pkg::OUT_W-1:0]  yaw_delta;
  modport source (output valid, pitch_delta, yaw_delta, input ready);
  modport sink (input valid, pitch_delta, yaw_delta, output ready);
endinterface

// File: hdl/pyd_sqrt_cell.sv
`timescale 1ns / 1ps
// One result bit of a restoring integer square root.
module pyd_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  pyd_pkg::sq_t  d,
  output pyd_pkg::sq_t  q
);
  logic [pyd_pkg::REM_W-1:0] r2;
  logic [pyd_pkg::REM_W-1:0] trial;
  pyd_pkg::sq_t              nxt;

  always_comb begin
    r2    = {d.rem[pyd_pkg::REM_W-3:0], d.rad[pyd_pkg::RAD_W-1 -: 2]};
    trial = pyd_pkg::REM_W'({d.root, 2'b01});
    nxt.rad = {d.rad[pyd_pkg::RAD_W-3:0], 2'b00};
    if (r2 >= trial) begin
      nxt.rem  = r2 - trial;
      nxt.root = {d.root[pyd_pkg::CW-2:0], 1'b1};
    end else begin
      nxt.rem  = r2;
      nxt.root = {d.root[pyd_pkg::CW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end
endmodule

// File: hdl/pyd_cordic_cell.sv
`timescale 1ns / 1ps
// One vectoring micro-rotation; a settled special case passes untouched.
module pyd_cordic_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pyd_pkg::IDX_W-1:0] idx,
  input  pyd_pkg::cd_t              d,
  output pyd_pkg::cd_t              q
);
  logic signed [pyd_pkg::XY_W-1:0]  dx;
  logic signed [pyd_pkg::XY_W-1:0]  dy;
  logic signed [pyd_pkg::ANG_W-1:0] ang;
  pyd_pkg::cd_t                     nxt;

  // x moves by the shifted y and y by the shifted x
  always_comb begin
    dx  = d.y >>> idx;
    dy  = d.x >>> idx;
    ang = pyd_pkg::stage_angle(idx);
    nxt = d;
    if (!d.held) begin
      if (d.y > 0) begin
        nxt.x   = d.x + dx;
        nxt.y   = d.y - dy;
        nxt.acc = d.acc + ang;
      end else begin
        nxt.x   = d.x - dx;
        nxt.y   = d.y + dy;
        nxt.acc = d.acc - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end
endmodule

// File: hdl/pyd_atan2.sv
`timescale 1ns / 1ps
// atan2(y, x) in degrees, wrapped to [0,360) and rounded.
module pyd_atan2 (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [pyd_pkg::OP_W-1:0]  y_in,
  input  logic signed [pyd_pkg::OP_W-1:0]  x_in,
  output logic        [pyd_pkg::OUT_W-1:0] angle
);
  localparam int RW = pyd_pkg::ANG_W - pyd_pkg::RND_SH;

  pyd_pkg::cd_t                     chain [pyd_pkg::CS+1];
  pyd_pkg::cd_t                     prep;
  logic signed [pyd_pkg::OP_W-1:0]  px;
  logic signed [pyd_pkg::OP_W-1:0]  py;
  logic signed [pyd_pkg::ANG_W-1:0] a;
  logic signed [pyd_pkg::ANG_W-1:0] wrapped;
  logic        [pyd_pkg::ANG_W-1:0] biased;
  logic        [RW-1:0]             r;

  always_comb begin
    px = x_in;
    py = y_in;
    prep.held = 1'b0;
    prep.acc  = '0;
    if (y_in == '0) begin
      prep.held = 1'b1;
      prep.acc  = (x_in < 0) ? pyd_pkg::DEG180 : '0;
    end else if (x_in == '0) begin
      prep.held = 1'b1;
      prep.acc  = (y_in > 0) ? pyd_pkg::DEG90 : -pyd_pkg::DEG90;
    end else if (x_in < 0) begin
      prep.acc = (y_in > 0) ? pyd_pkg::DEG180 : -pyd_pkg::DEG180;
      px = -x_in;
      py = -y_in;
    end
    prep.x = pyd_pkg::XY_W'(px) <<< pyd_pkg::PRESCALE;
    prep.y = pyd_pkg::XY_W'(py) <<< pyd_pkg::PRESCALE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= prep;
    end
  end

  for (genvar g = 0; g < pyd_pkg::CS; g++) begin : g_cell
    pyd_cordic_cell u_cell (
      .clk (clk),
      .en  (en),
      .idx (pyd_pkg::IDX_W'(g)),
      .d   (chain[g]),
      .q   (chain[g+1])
    );
  end

  always_comb begin
    a = chain[pyd_pkg::CS].acc;
    if (a < 0) begin
      a = a + pyd_pkg::DEG360;
    end else if (a >= pyd_pkg::DEG360) begin
      a = a - pyd_pkg::DEG360;
    end
    biased = wrapped + pyd_pkg::ANG_W'(1 << (pyd_pkg::RND_SH - 1));
    r = biased[pyd_pkg::ANG_W-1:pyd_pkg::RND_SH];
    if (r >= RW'(pyd_pkg::FULL)) begin
      r = r - RW'(pyd_pkg::FULL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wrapped <= a;
      angle   <= r[pyd_pkg::OUT_W-1:0];
    end
  end
endmodule

// File: hdl/pitch_yaw_difference_angles.sv
`timescale 1ns / 1ps
// Pitch and yaw difference between a current vector and a target direction.
// Input channel vec carries six signed Q8.8 components per word; output
// channel delta carries pitch_delta and yaw_delta, degrees in [0,360) with
// 8 fraction bits. Both use valid/ready; a word moves when both are high.
// Throughput is one word per cycle while delta is not stalled: the squaring
// stages, the sixteen square-root cells and the sixteen CORDIC cells are all
// pipelined, so every stage hands its word on whenever the pipeline advances.
// The whole pipeline advances together; it halts only while a result sits
// on delta and the receiver holds ready low, and vec.ready is low for
// exactly those cycles. No word is lost or repeated across a stall.
// Synchronous reset clears the valid bits of every stage; data registers
// are not reset and are ignored until a valid word reaches them.
module pitch_yaw_difference_angles (
  input logic         clk,
  input logic         rst,
  pyd_vec_if.sink     vec,
  pyd_delta_if.source delta
);
  logic                               en;
  logic [pyd_pkg::DEPTH-1:0]          vld;
  pyd_pkg::vec_t                      vin;
  pyd_pkg::vec_t                      side [pyd_pkg::SIDE];
  logic [pyd_pkg::RAD_W-1:0]          sq_cx, sq_cz, sq_tx, sq_tz;
  pyd_pkg::sq_t                       cur_sq [pyd_pkg::SQ+1];
  pyd_pkg::sq_t                       tgt_sq [pyd_pkg::SQ+1];
  pyd_pkg::vec_t                      al;
  logic signed [pyd_pkg::OP_W-1:0]    cp_y, tp_y, cw_y, tw_y;
  logic signed [pyd_pkg::OP_W-1:0]    cp_x, tp_x, cw_x, tw_x;
  logic        [pyd_pkg::OUT_W-1:0]   cp, tp, cw, tw;
  logic signed [pyd_pkg::OUT_W:0]     dp, dw;

  // Advance everything unless a result is waiting on a stalled receiver.
  assign en        = !delta.valid || delta.ready;
  assign vec.ready = en;
  assign delta.valid = vld[pyd_pkg::DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[pyd_pkg::DEPTH-2:0], vec.valid};
    end
  end

  // Capture the word, square, then sum.
  always_ff @(posedge clk) begin
    if (en) begin
      vin <= '{vec.cur_x, vec.cur_y, vec.cur_z, vec.to_x, vec.to_y, vec.to_z};
      sq_cx <= pyd_pkg::RAD_W'(vin.cx * vin.cx);
      sq_cz <= pyd_pkg::RAD_W'(vin.cz * vin.cz);
      sq_tx <= pyd_pkg::RAD_W'(vin.tx * vin.tx);
      sq_tz <= pyd_pkg::RAD_W'(vin.tz * vin.tz);
      cur_sq[0] <= '{sq_cx + sq_cz, '0, '0};
      tgt_sq[0] <= '{sq_tx + sq_tz, '0, '0};
      side[0] <= vin;
      for (int k = 1; k < pyd_pkg::SIDE; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Horizontal lengths, one root bit per cell.
  for (genvar g = 0; g < pyd_pkg::SQ; g++) begin : g_sqrt
    pyd_sqrt_cell u_cur (.clk(clk), .en(en), .d(cur_sq[g]), .q(cur_sq[g+1]));
    pyd_sqrt_cell u_tgt (.clk(clk), .en(en), .d(tgt_sq[g]), .q(tgt_sq[g+1]));
  end

  // Operands: pitch = atan2(-y, hypot(x,z)), yaw = atan2(-z, x).
  assign al   = side[pyd_pkg::SIDE-1];
  assign cp_y = -pyd_pkg::OP_W'(al.cy);
  assign tp_y = -pyd_pkg::OP_W'(al.ty);
  assign cw_y = -pyd_pkg::OP_W'(al.cz);
  assign tw_y = -pyd_pkg::OP_W'(al.tz);
  assign cp_x = $signed({1'b0, cur_sq[pyd_pkg::SQ].root});
  assign tp_x = $signed({1'b0, tgt_sq[pyd_pkg::SQ].root});
  assign cw_x = pyd_pkg::OP_W'(al.cx);
  assign tw_x = pyd_pkg::OP_W'(al.tx);

  pyd_atan2 u_cur_pitch (.clk(clk), .en(en), .y_in(cp_y), .x_in(cp_x), .angle(cp));
  pyd_atan2 u_tgt_pitch (.clk(clk), .en(en), .y_in(tp_y), .x_in(tp_x), .angle(tp));
  pyd_atan2 u_cur_yaw   (.clk(clk), .en(en), .y_in(cw_y), .x_in(cw_x), .angle(cw));
  pyd_atan2 u_tgt_yaw   (.clk(clk), .en(en), .y_in(tw_y), .x_in(tw_x), .angle(tw));

  // Target minus current, wrapped back into [0,360).
  always_comb begin
    dp = $signed({1'b0, tp}) - $signed({1'b0, cp});
    dw = $signed({1'b0, tw}) - $signed({1'b0, cw});
    if (dp < 0) begin
      dp = dp + $signed({1'b0, pyd_pkg::FULL});
    end
    if (dw < 0) begin
      dw = dw + $signed({1'b0, pyd_pkg::FULL});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      delta.pitch_delta <= dp[pyd_pkg::OUT_W-1:0];
      delta.yaw_delta   <= dw[pyd_pkg::OUT_W-1:0];
    end
  end
endmodule

// File: hdl/pyd_checker.sv
`timescale 1ns / 1ps
`include "pitch_yaw_difference_angles_assert.svh"
module pyd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [pyd_pkg::OUT_W-1:0] pitch_delta,
  input logic [pyd_pkg::OUT_W-1:0] yaw_delta
);
  `PYD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  `PYD_ASSERT(a_ready_follows_out, clk, rst, in_ready == (!out_valid || out_ready))
  `PYD_ASSERT(a_out_held, clk, rst, out_valid && !out_ready |=> out_valid)
  `PYD_ASSERT(a_range, clk, rst, out_valid |-> pitch_delta < pyd_pkg::FULL && yaw_delta < pyd_pkg::FULL)
endmodule

bind pitch_yaw_difference_angles pyd_checker u_pyd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (vec.ready),
  .out_valid   (delta.valid),
  .out_ready   (delta.ready),
  .pitch_delta (delta.pitch_delta),
  .yaw_delta   (delta.yaw_delta)
);
